### hdl/lsps_pkg.sv
`default_nettype none

package lsps_pkg;

    localparam int SLOTS_PER_WORD     = 4;
    localparam int MAX_SITES_DEF      = 4096;
    localparam int WORDS_PER_SITE_DEF = 2;

    localparam int FUNC_W    = 3;
    localparam int COORD_W   = 6;
    localparam int VAL_W     = 8;
    localparam int SLOT_W    = 4;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 4;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam int SIZE_RESET = 16;

    localparam logic [FUNC_W-1:0] FN_RD_TYPE   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_WR_TYPE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_OCCUPANCY = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RD_SLOT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_ADD       = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_SLOT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
        logic [VAL_W-1:0]   value_in;
        logic [SLOT_W-1:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  data_out;
        logic [OCC_W-1:0]  occupancy;
    } rsp_t;

endpackage

`default_nettype wire

### hdl/lattice_site_particle_store_core.sv
// Channel   Ports                        Handshake
// -------   --------------------------   -----------------------------------
// request   start, busy, req             taken when start && !busy
// result    done, rsp                    one cycle strobe, cannot be held off
// config    cfg_we, cfg_idx, cfg_data    written when cfg_we, no wait
//
// An item passes MUL1, MUL2 and ADDR; write type and errors finish in ADDR, a read type
// adds TYPE, scans alternate SCAN (one slot memory read per word) and EVAL (check)
// for each slot word touched, and a site clear adds WIPE (one word write per cycle).
// Two multiply stages form the site index and lattice size before any access.
// After reset both memories are zeroed in the INIT state
// with busy high. Results are never stalled.
`default_nettype none

module lattice_site_particle_store_core
    import lsps_pkg::*;
#(
    parameter int MAX_SITES      = MAX_SITES_DEF,
    parameter int WORDS_PER_SITE = WORDS_PER_SITE_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire req_t                 req,
    output logic                      done,
    output rsp_t                      rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int SLOTS_PER_SITE = WORDS_PER_SITE * SLOTS_PER_WORD;
    localparam int WORDS   = MAX_SITES * WORDS_PER_SITE;
    localparam int SITE_AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WCNT_W  = (WORDS_PER_SITE > 1) ? $clog2(WORDS_PER_SITE) : 1;
    localparam int SEL_W   = $clog2(SLOTS_PER_WORD);
    localparam int WSEL_W  = SLOT_W - SEL_W;
    localparam int WORD_W  = SLOTS_PER_WORD * VAL_W;
    localparam int YSX_W   = COORD_W + CFG_W;
    localparam int SXY_W   = 2 * CFG_W;
    localparam int ZSXY_W  = COORD_W + SXY_W;
    localparam int NS_W    = 3 * CFG_W;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_ADDR = 4'd4;
    localparam logic [3:0] S_TYPE = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_EVAL = 4'd7;
    localparam logic [3:0] S_WIPE = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic               done_reg, done_next;
    logic [WORD_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0]   size_x_reg, size_x_next;
    logic [CFG_W-1:0]   size_y_reg, size_y_next;
    logic [CFG_W-1:0]   size_z_reg, size_z_next;

    req_t               req_reg, req_next;
    rsp_t               rsp_reg, rsp_next;
    logic [YSX_W-1:0]   ysx_reg, ysx_next;
    logic [SXY_W-1:0]   sxy_reg, sxy_next;
    logic [ZSXY_W-1:0]  zsxy_reg, zsxy_next;
    logic [NS_W-1:0]    nsites_reg, nsites_next;
    logic               bad_reg, bad_next;
    logic [WORD_AW-1:0] waddr_reg, waddr_next;
    logic [WCNT_W-1:0]  wcnt_reg, wcnt_next;

    logic [VAL_W-1:0]   site_mem [MAX_SITES];
    logic [WORD_W-1:0]  slot_mem [WORDS];
    logic [VAL_W-1:0]   site_rdata_reg;
    logic [WORD_W-1:0]  slot_rdata_reg;

    logic               site_we;
    logic [SITE_AW-1:0] site_wa;
    logic [VAL_W-1:0]   site_wd;
    logic               slot_we;
    logic [WORD_AW-1:0] slot_wa;
    logic [WORD_W-1:0]  slot_wd;

    logic [NS_W-1:0]    site_sum;
    logic [SITE_AW-1:0] site_addr;
    logic               oob;
    logic               last_word;
    logic               zero_found;
    logic [SEL_W-1:0]   zero_idx;
    logic [WORD_W-1:0]  merged;

    assign site_sum  = NS_W'(req_reg.coord_x) + NS_W'(ysx_reg) + NS_W'(zsxy_reg);
    assign site_addr = site_sum[SITE_AW-1:0];
    assign oob       = bad_reg || (nsites_reg > NS_W'(MAX_SITES));
    assign last_word = (wcnt_reg == WCNT_W'(WORDS_PER_SITE - 1));

    // lowest empty slot in the fetched word
    always_comb
    begin
        zero_found = 1'b0;
        zero_idx   = '0;
        for (int i = SLOTS_PER_WORD - 1; i >= 0; i--)
        begin
            if (slot_rdata_reg[i*VAL_W +: VAL_W] == '0)
            begin
                zero_found = 1'b1;
                zero_idx   = SEL_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS_PER_WORD; i++)
        begin
            merged[i*VAL_W +: VAL_W] = (SEL_W'(i) == zero_idx) ? req_reg.value_in
                                                               : slot_rdata_reg[i*VAL_W +: VAL_W];
        end
    end

    always_comb
    begin
        size_x_next = size_x_reg;
        size_y_next = size_y_reg;
        size_z_next = size_z_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_SIZE_X: size_x_next = cfg_data;
                REG_SIZE_Y: size_y_next = cfg_data;
                REG_SIZE_Z: size_z_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        req_next     = req_reg;
        rsp_next     = rsp_reg;
        ysx_next     = ysx_reg;
        sxy_next     = sxy_reg;
        zsxy_next    = zsxy_reg;
        nsites_next  = nsites_reg;
        bad_next     = bad_reg;
        waddr_next   = waddr_reg;
        wcnt_next    = wcnt_reg;
        site_we      = 1'b0;
        site_wa      = site_addr;
        site_wd      = req_reg.value_in;
        slot_we      = 1'b0;
        slot_wa      = waddr_reg;
        slot_wd      = '0;

        unique case (state_reg)
            S_INIT:
            begin
                slot_we      = 1'b1;
                slot_wa      = clr_cnt_reg;
                site_we      = ({1'b0, clr_cnt_reg} < (WORD_AW + 1)'(MAX_SITES));
                site_wa      = clr_cnt_reg[SITE_AW-1:0];
                site_wd      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == WORD_AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                ysx_next   = YSX_W'(req_reg.coord_y) * YSX_W'(size_x_reg);
                sxy_next   = SXY_W'(size_x_reg) * SXY_W'(size_y_reg);
                bad_next   = ({1'b0, req_reg.coord_x} >= size_x_reg)
                          || ({1'b0, req_reg.coord_y} >= size_y_reg)
                          || ({1'b0, req_reg.coord_z} >= size_z_reg);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                zsxy_next   = ZSXY_W'(req_reg.coord_z) * ZSXY_W'(sxy_reg);
                nsites_next = NS_W'(sxy_reg) * NS_W'(size_z_reg);
                state_next  = S_ADDR;
            end
            S_ADDR:
            begin
                rsp_next   = '0;
                waddr_next = site_sum[WORD_AW-1:0];
                wcnt_next  = '0;
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (req_reg.func > FN_CLEAR)
                begin
                    rsp_next.status = ST_OK;
                end
                else if (oob)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    case (req_reg.func) inside
                        FN_RD_TYPE:
                        begin
                            done_next  = 1'b0;
                            state_next = S_TYPE;
                        end
                        FN_WR_TYPE:
                        begin
                            site_we = 1'b1;
                        end
                        FN_RD_SLOT:
                        begin
                            if ({1'b0, req_reg.slot_index} >= (SLOT_W + 1)'(SLOTS_PER_SITE))
                            begin
                                rsp_next.status = ST_SLOT;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        FN_OCCUPANCY, FN_ADD:
                        begin
                            done_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        FN_CLEAR:
                        begin
                            done_next  = 1'b0;
                            state_next = S_WIPE;
                        end
                        default: ;
                    endcase
                end
            end
            S_TYPE:
            begin
                rsp_next.data_out = site_rdata_reg;
                done_next         = 1'b1;
                state_next        = S_IDLE;
            end
            S_SCAN:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                wcnt_next  = wcnt_reg + 1'b1;
                waddr_next = waddr_reg + nsites_reg[WORD_AW-1:0];
                state_next = S_SCAN;
                case (req_reg.func)
                    FN_RD_SLOT:
                    begin
                        if (WSEL_W'(wcnt_reg) == req_reg.slot_index[SLOT_W-1:SEL_W])
                        begin
                            rsp_next.data_out =
                                slot_rdata_reg[req_reg.slot_index[SEL_W-1:0]*VAL_W +: VAL_W];
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    FN_OCCUPANCY:
                    begin
                        if (zero_found)
                        begin
                            rsp_next.occupancy = OCC_W'({wcnt_reg, zero_idx});
                            done_next          = 1'b1;
                            state_next         = S_IDLE;
                        end
                        else if (last_word)
                        begin
                            rsp_next.occupancy = OCC_W'(SLOTS_PER_SITE);
                            done_next          = 1'b1;
                            state_next         = S_IDLE;
                        end
                    end
                    FN_ADD:
                    begin
                        if (zero_found)
                        begin
                            slot_we    = 1'b1;
                            slot_wd    = merged;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (last_word)
                        begin
                            rsp_next.status = ST_FULL;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WIPE:
            begin
                slot_we    = 1'b1;
                wcnt_next  = wcnt_reg + 1'b1;
                waddr_next = waddr_reg + nsites_reg[WORD_AW-1:0];
                if (last_word)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            done_reg    <= 1'b0;
            clr_cnt_reg <= '0;
            size_x_reg  <= CFG_W'(SIZE_RESET);
            size_y_reg  <= CFG_W'(SIZE_RESET);
            size_z_reg  <= CFG_W'(SIZE_RESET);
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            clr_cnt_reg <= clr_cnt_next;
            size_x_reg  <= size_x_next;
            size_y_reg  <= size_y_next;
            size_z_reg  <= size_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
        ysx_reg    <= ysx_next;
        sxy_reg    <= sxy_next;
        zsxy_reg   <= zsxy_next;
        nsites_reg <= nsites_next;
        bad_reg    <= bad_next;
        waddr_reg  <= waddr_next;
        wcnt_reg   <= wcnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (site_we)
        begin
            site_mem[site_wa] <= site_wd;
        end
        site_rdata_reg <= site_mem[site_addr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rdata_reg <= slot_mem[waddr_reg];
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

### hdl/lsps_checker.sv
`default_nettype none

module lsps_checker
    import lsps_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t rsp
);

    // result comes out as the block drops back to idle
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe without a finishing item");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.data_out == '0 && rsp.occupancy == '0))
        else $error("error result carries data");

endmodule

bind lattice_site_particle_store_core lsps_checker u_lsps_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

### tb/lsps_tb_pkg.sv
package lsps_tb_pkg;
    import lsps_pkg::*;

    localparam int SLOTS_PER_SITE = SLOTS_PER_WORD * WORDS_PER_SITE_DEF;
    localparam int SLOT_DEPTH     = MAX_SITES_DEF * SLOTS_PER_SITE;

    class lattice_scoreboard;
        bit [VAL_W-1:0] site_type_mem [MAX_SITES_DEF];
        bit [VAL_W-1:0] particle_mem [SLOT_DEPTH];
        int unsigned    dim_x;
        int unsigned    dim_y;
        int unsigned    dim_z;
        rsp_t           rsp_due_q [$];
        int unsigned    errors;

        function new();
            dim_x  = SIZE_RESET;
            dim_y  = SIZE_RESET;
            dim_z  = SIZE_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_SIZE_X: dim_x = val;
                REG_SIZE_Y: dim_y = val;
                REG_SIZE_Z: dim_z = val;
                default: ;
            endcase
        endfunction

        // slot word w of a site sits one lattice volume above word w-1
        function int unsigned slot_addr(int unsigned site, int unsigned nsites,
                                        int unsigned slot);
            return ((site + nsites * (slot / SLOTS_PER_WORD)) * SLOTS_PER_WORD
                    + slot % SLOTS_PER_WORD) % SLOT_DEPTH;
        endfunction

        function void note_request(req_t r);
            rsp_t        e;
            int unsigned nsites;
            int unsigned site;
            int unsigned s;
            int unsigned a;
            bit          placed;
            e      = '0;
            nsites = dim_x * dim_y * dim_z;
            if (r.func <= FN_CLEAR)
            begin
                if (nsites > MAX_SITES_DEF || r.coord_x >= dim_x || r.coord_y >= dim_y ||
                    r.coord_z >= dim_z)
                begin
                    e.status = ST_RANGE;
                end
                else
                begin
                    site = (r.coord_x + r.coord_y * dim_x + r.coord_z * dim_x * dim_y)
                           % MAX_SITES_DEF;
                    case (r.func)
                        FN_RD_TYPE: e.data_out = site_type_mem[site];
                        FN_WR_TYPE: site_type_mem[site] = r.value_in;
                        FN_OCCUPANCY:
                        begin
                            s = 0;
                            while (s < SLOTS_PER_SITE &&
                                   particle_mem[slot_addr(site, nsites, s)] != 0)
                                s++;
                            e.occupancy = OCC_W'(s);
                        end
                        FN_RD_SLOT:
                        begin
                            if (r.slot_index >= SLOTS_PER_SITE)
                                e.status = ST_SLOT;
                            else
                                e.data_out = particle_mem[slot_addr(site, nsites,
                                                                    r.slot_index)];
                        end
                        FN_ADD:
                        begin
                            placed = 1'b0;
                            for (s = 0; s < SLOTS_PER_SITE; s++)
                            begin
                                a = slot_addr(site, nsites, s);
                                if (!placed && particle_mem[a] == 0)
                                begin
                                    particle_mem[a] = r.value_in;
                                    placed = 1'b1;
                                end
                            end
                            e.status = placed ? ST_OK : ST_FULL;
                        end
                        default:
                        begin
                            for (s = 0; s < SLOTS_PER_SITE; s++)
                                particle_mem[slot_addr(site, nsites, s)] = '0;
                        end
                    endcase
                end
            end
            rsp_due_q = {rsp_due_q, e};
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (rsp_due_q.size() == 0)
            begin
                $error("unexpected result: status %0d data_out %0d occupancy %0d",
                       got.status, got.data_out, got.occupancy);
                errors++;
                return;
            end
            e = rsp_due_q.pop_front();
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                errors++;
            end
            if (got.data_out !== e.data_out)
            begin
                $error("data_out: expected %0d, actual %0d", e.data_out, got.data_out);
                errors++;
            end
            if (got.occupancy !== e.occupancy)
            begin
                $error("occupancy: expected %0d, actual %0d", e.occupancy, got.occupancy);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return rsp_due_q.size();
        endfunction
    endclass
endpackage

### tb/lattice_site_particle_store_core_tb.sv
module lattice_site_particle_store_core_tb;
    import lsps_pkg::*;
    import lsps_tb_pkg::*;

    localparam logic [FUNC_W-1:0]    FN_NOP_A = 3'd6;
    localparam logic [FUNC_W-1:0]    FN_NOP_B = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int                   LIMIT    = 400000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 start    = 1'b0;
    logic                 busy;
    req_t                 req      = '0;
    logic                 done;
    rsp_t                 rsp;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    lattice_scoreboard sb;
    int unsigned       burst_left = 0;

    lattice_site_particle_store_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(rsp);
    end

    initial
    begin
        #(LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic req_t mk_req(logic [FUNC_W-1:0] f, int unsigned x, int unsigned y,
                                    int unsigned z, int unsigned val, int unsigned slot);
        req_t r;
        r.func       = f;
        r.coord_x    = COORD_W'(x);
        r.coord_y    = COORD_W'(y);
        r.coord_z    = COORD_W'(z);
        r.value_in   = VAL_W'(val);
        r.slot_index = SLOT_W'(slot);
        return r;
    endfunction

    function automatic int unsigned pick_coord(int unsigned lim);
        if (lim == 0 || $urandom_range(0, 19) == 0)
            return $urandom_range(0, 63);
        if (lim > 64)
            lim = 64;
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic req_t random_request();
        int unsigned      p;
        int unsigned      v;
        logic [FUNC_W-1:0] f;
        p = $urandom_range(0, 99);
        if (p < 10)      f = FN_RD_TYPE;
        else if (p < 20) f = FN_WR_TYPE;
        else if (p < 35) f = FN_OCCUPANCY;
        else if (p < 55) f = FN_RD_SLOT;
        else if (p < 85) f = FN_ADD;
        else if (p < 95) f = FN_CLEAR;
        else if (p < 98) f = FN_NOP_A;
        else             f = FN_NOP_B;
        p = $urandom_range(0, 9);
        v = (p == 0) ? 0 : (p == 1) ? 255 : $urandom_range(1, 255);
        return mk_req(f, pick_coord(sb.dim_x), pick_coord(sb.dim_y), pick_coord(sb.dim_z), v,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(8, 15)
                                                  : $urandom_range(0, 7));
    endfunction

    function automatic int unsigned gap_len();
        int unsigned p;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 3)
        begin
            burst_left = $urandom_range(15, 40);
            return 0;
        end
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_request(input req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r);
    endtask

    task automatic pause_sender();
        int unsigned n;
        n = gap_len();
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic issue(input req_t r);
        send_request(r);
        pause_sender();
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() != 0 || busy)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        sb.set_reg(idx, CFG_W'(val));
    endtask

    task automatic set_lattice(input int unsigned sx, input int unsigned sy,
                               input int unsigned sz);
        drain();
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned sx, input int unsigned sy,
                                input int unsigned sz, input int unsigned n);
        set_lattice(sx, sy, sz);
        repeat (n) issue(random_request());
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);

        // default 16x16x16 lattice
        issue(mk_req(FN_WR_TYPE, 0, 0, 0, 8'hFF, 0));
        issue(mk_req(FN_RD_TYPE, 0, 0, 0, 0, 0));
        issue(mk_req(FN_WR_TYPE, 15, 15, 15, 8'h5A, 15));
        issue(mk_req(FN_RD_TYPE, 15, 15, 15, 0, 0));
        issue(mk_req(FN_RD_TYPE, 16, 0, 0, 0, 0));
        issue(mk_req(FN_ADD, 0, 63, 0, 8'h11, 0));
        for (int i = 0; i < SLOTS_PER_SITE; i++)
            issue(mk_req(FN_ADD, 1, 2, 3, (i == 0) ? 8'hFF : i, 0));
        issue(mk_req(FN_ADD, 1, 2, 3, 8'h33, 0));
        issue(mk_req(FN_OCCUPANCY, 1, 2, 3, 0, 0));
        issue(mk_req(FN_RD_SLOT, 1, 2, 3, 0, 7));
        issue(mk_req(FN_RD_SLOT, 1, 2, 3, 0, 8));
        issue(mk_req(FN_RD_SLOT, 1, 2, 3, 0, 15));
        issue(mk_req(FN_CLEAR, 1, 2, 3, 0, 0));
        issue(mk_req(FN_OCCUPANCY, 1, 2, 3, 0, 0));
        issue(mk_req(FN_ADD, 1, 2, 3, 0, 0));
        issue(mk_req(FN_OCCUPANCY, 1, 2, 3, 0, 0));
        issue(mk_req(FN_NOP_A, 1, 2, 3, 8'hFF, 15));
        issue(mk_req(FN_NOP_B, 63, 63, 63, 8'hFF, 15));

        random_phase(2, 3, 2, 140);
        random_phase(1, 1, 1, 40);
        random_phase(64, 64, 1, 60);
        random_phase(127, 1, 1, 50);
        random_phase(1, 127, 32, 50);
        random_phase(0, 4, 4, 15);
        random_phase(64, 64, 2, 15);
        random_phase(127, 127, 127, 10);
        drain();
        write_reg(REG_NONE, 5);
        cfg_we <= 1'b0;
        random_phase(3, 5, 2, 140);
        drain();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### filelist.f
hdl/lsps_pkg.sv
hdl/lattice_site_particle_store_core.sv
hdl/lsps_checker.sv
tb/lsps_tb_pkg.sv
tb/lattice_site_particle_store_core_tb.sv
